### src/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Shared types, widths, latencies and constants of the axis-angle rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package aar_pkg;

  // Field widths.
  localparam int ANGLE_W = 16;
  localparam int AXIS_W  = 16;
  localparam int M_W     = 16;
  localparam int LEN_W   = 32;

  // Square root gives one root bit per stage, the divider one quotient bit.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  // Register counts of the axis path: squares, root bits; setup, quotient
  // bits, signed result.
  localparam int SQRT_LAT = SQRT_STEPS + 1;
  localparam int DIV_LAT  = DIV_STEPS + 2;

  // Register counts of the angle path around the rotator: reduce, scale,
  // correct, fold; then the sign restore after the rotator.
  localparam int SC_PRE_LAT  = 4;
  localparam int SC_POST_LAT = 1;

  // One turn in 1/64-degree units, and the parts of its scaling to 2^32.
  localparam int FULL_TURN = 23040;
  localparam logic [17:0] THETA_MUL = 18'd186413;   // floor(2^23 / 45)
  localparam logic [19:0] THETA_ADD = 20'd22;       // floor(45 / 2), for rounding
  localparam logic [19:0] THETA_RES = 20'd23;       // 2^23 mod 45
  localparam logic [19:0] RECIP_DEN = 20'd45;       // 23040 / 512
  localparam logic [20:0] RECIP_K   = 21'd1491308;  // floor(2^26 / 45)
  localparam int          RECIP_SH  = 26;

  // Q30 constants.
  localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN   = 33'sd2147483648;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // Q2.14 limit.
  localparam logic signed [17:0] Q14_MAX = 18'sd16384;

  localparam int ATAN_ENTRIES = 24;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [15:0] q14_t;

  // Axis word as it travels through the norm path.
  typedef struct packed {
    logic                     zero;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
  } axis_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_lut(input int unsigned idx);
    case (idx)
      0:       atan_lut = 32'h20000000;
      1:       atan_lut = 32'h12E4051E;
      2:       atan_lut = 32'h09FB385B;
      3:       atan_lut = 32'h051111D4;
      4:       atan_lut = 32'h028B0D43;
      5:       atan_lut = 32'h0145D7E1;
      6:       atan_lut = 32'h00A2F61E;
      7:       atan_lut = 32'h00517C55;
      8:       atan_lut = 32'h0028BE53;
      9:       atan_lut = 32'h00145F2F;
      10:      atan_lut = 32'h000A2F98;
      11:      atan_lut = 32'h000517CC;
      12:      atan_lut = 32'h00028BE6;
      13:      atan_lut = 32'h000145F3;
      14:      atan_lut = 32'h0000A2F9;
      15:      atan_lut = 32'h0000517C;
      16:      atan_lut = 32'h000028BE;
      17:      atan_lut = 32'h0000145F;
      18:      atan_lut = 32'h00000A2F;
      19:      atan_lut = 32'h00000517;
      20:      atan_lut = 32'h0000028B;
      21:      atan_lut = 32'h00000145;
      22:      atan_lut = 32'h000000A2;
      23:      atan_lut = 32'h00000051;
      default: atan_lut = 32'h00000000;
    endcase
  endfunction

endpackage

### src/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis-angle to 3x3 rotation matrix in Q2.14, fully pipelined.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ---------------------------------------
//   in       in_valid_i / in_stall_o angle_i, axis_x_i, axis_y_i, axis_z_i
//   out      out_valid_o/out_stall_i m00_o .. m22_o, zero_axis_o
//
// One word enters per cycle while the output is not stalled; a word passes
// the squared length and square root, the divider and the matrix stages.
// The angle runs through a delay line and the CORDIC rotator, whose
// CORDIC_STEPS stages set the delay line length to 61 - CORDIC_STEPS.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled output word freezes the whole pipeline in place, so no word is
// lost or repeated; input is stalled in that same cycle.
//
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [aar_pkg::ANGLE_W-1:0] angle_i,
  input  logic signed [aar_pkg::AXIS_W-1:0]  axis_x_i,
  input  logic signed [aar_pkg::AXIS_W-1:0]  axis_y_i,
  input  logic signed [aar_pkg::AXIS_W-1:0]  axis_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [aar_pkg::M_W-1:0]     m00_o,
  output logic signed [aar_pkg::M_W-1:0]     m01_o,
  output logic signed [aar_pkg::M_W-1:0]     m02_o,
  output logic signed [aar_pkg::M_W-1:0]     m10_o,
  output logic signed [aar_pkg::M_W-1:0]     m11_o,
  output logic signed [aar_pkg::M_W-1:0]     m12_o,
  output logic signed [aar_pkg::M_W-1:0]     m20_o,
  output logic signed [aar_pkg::M_W-1:0]     m21_o,
  output logic signed [aar_pkg::M_W-1:0]     m22_o,
  output logic                               zero_axis_o
);
  import aar_pkg::*;

  localparam int SC_LAT    = SC_PRE_LAT + CORDIC_STEPS + SC_POST_LAT;
  localparam int ANG_DELAY = SQRT_LAT + DIV_LAT - SC_LAT;

  logic          en;
  axis_t         axis_in;
  logic          sq_vld;
  logic [LEN_W-1:0] sq_len;
  axis_t         sq_axis;
  logic          dv_vld;
  logic          dv_zero;
  q30_t          ux, uy, uz;
  q30_t          cos_w, sin_w;
  q14_t          m_w [9];
  logic signed [ANGLE_W-1:0] ang_dly_q [ANG_DELAY];

  // The pipeline moves unless a finished word waits at the output.
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  assign axis_in.zero = (axis_x_i == '0) && (axis_y_i == '0) && (axis_z_i == '0);
  assign axis_in.ax   = axis_x_i;
  assign axis_in.ay   = axis_y_i;
  assign axis_in.az   = axis_z_i;

  // Axis length.
  aar_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .axis_i (axis_in),
    .vld_o  (sq_vld),
    .len_o  (sq_len),
    .axis_o (sq_axis)
  );

  // Unit axis.
  aar_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .len_i  (sq_len),
    .axis_i (sq_axis),
    .vld_o  (dv_vld),
    .zero_o (dv_zero),
    .ux_o   (ux),
    .uy_o   (uy),
    .uz_o   (uz)
  );

  // Angle delay line, so that sine and cosine meet the unit axis.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_dly_q[0] <= angle_i;
      for (int k = 1; k < ANG_DELAY; k++) ang_dly_q[k] <= ang_dly_q[k-1];
    end
  end

  // Cosine and sine.
  aar_sincos #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_sincos (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_dly_q[ANG_DELAY-1]),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // Matrix entries.
  aar_mat u_mat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .zero_i (dv_zero),
    .ux_i   (ux),
    .uy_i   (uy),
    .uz_i   (uz),
    .cos_i  (cos_w),
    .sin_i  (sin_w),
    .vld_o  (out_valid_o),
    .zero_o (zero_axis_o),
    .m_o    (m_w)
  );

  assign m00_o = m_w[0];
  assign m01_o = m_w[1];
  assign m02_o = m_w[2];
  assign m10_o = m_w[3];
  assign m11_o = m_w[4];
  assign m12_o = m_w[5];
  assign m20_o = m_w[6];
  assign m21_o = m_w[7];
  assign m22_o = m_w[8];

  // A zero axis word carries the identity.
  a_zero_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_axis_o |->
      m00_o == 16'sd16384 && m11_o == 16'sd16384 && m22_o == 16'sd16384 &&
      m01_o == 16'sd0 && m12_o == 16'sd0 && m20_o == 16'sd0)
    else $error("zero axis word is not the identity");

  // Saturation keeps the diagonal within one.
  a_diag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      m00_o <= 16'sd16384 && m00_o >= -16'sd16384 &&
      m11_o <= 16'sd16384 && m11_o >= -16'sd16384 &&
      m22_o <= 16'sd16384 && m22_o >= -16'sd16384)
    else $error("diagonal entry beyond saturation limit");

  // Saturation keeps the off-diagonal entries m01, m10 and m21 within one.
  a_offdiag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      m01_o <= 16'sd16384 && m01_o >= -16'sd16384 &&
      m10_o <= 16'sd16384 && m10_o >= -16'sd16384 &&
      m21_o <= 16'sd16384 && m21_o >= -16'sd16384)
    else $error("off-diagonal entry beyond saturation limit");

  // A frozen pipeline keeps the waiting word's flag.
  a_freeze_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(zero_axis_o))
    else $error("pipeline moved while frozen");

endmodule

### src/aar_sqrt.sv
// ----------------------------------------------------------------------------
// aar_sqrt
// Squared axis length, then a pipelined digit-by-digit square root of
// n2 * 2^32, one root bit per stage. Gives the axis length in Q16.
// ----------------------------------------------------------------------------
module aar_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  aar_pkg::axis_t              axis_i,
  output logic                        vld_o,
  output logic [aar_pkg::LEN_W-1:0]   len_o,
  output aar_pkg::axis_t              axis_o
);
  import aar_pkg::*;

  logic [33:0]   rem_q  [SQRT_STEPS+1];
  logic [33:0]   rem_d  [SQRT_STEPS+1];
  logic [31:0]   root_q [SQRT_STEPS+1];
  logic [31:0]   root_d [SQRT_STEPS+1];
  logic [31:0]   rad_q  [SQRT_STEPS+1];
  logic [31:0]   rad_d  [SQRT_STEPS+1];
  axis_t         axis_q [SQRT_STEPS+1];
  logic          vld_q  [SQRT_STEPS+1];

  logic signed [31:0] sq_x, sq_y, sq_z;

  // Squares of the components; each fits in 31 bits, their sum in 32.
  assign sq_x = 32'(axis_i.ax) * 32'(axis_i.ax);
  assign sq_y = 32'(axis_i.ay) * 32'(axis_i.ay);
  assign sq_z = 32'(axis_i.az) * 32'(axis_i.az);

  // Stage zero loads the radicand; each later stage settles one root bit.
  always_comb begin
    logic [35:0] acc;
    logic [35:0] trial;
    rem_d[0]  = '0;
    root_d[0] = '0;
    rad_d[0]  = unsigned'(sq_x) + unsigned'(sq_y) + unsigned'(sq_z);
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      acc   = {rem_q[k-1], rad_q[k-1][31:30]};
      trial = {2'b00, root_q[k-1], 2'b01};
      if (acc >= trial) begin
        rem_d[k]  = 34'(acc - trial);
        root_d[k] = {root_q[k-1][30:0], 1'b1};
      end else begin
        rem_d[k]  = acc[33:0];
        root_d[k] = {root_q[k-1][30:0], 1'b0};
      end
      rad_d[k] = {rad_q[k-1][29:0], 2'b00};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SQRT_STEPS; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= SQRT_STEPS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axis_q[0] <= axis_i;
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
      for (int k = 1; k <= SQRT_STEPS; k++) axis_q[k] <= axis_q[k-1];
    end
  end

  assign vld_o  = vld_q[SQRT_STEPS];
  assign len_o  = root_q[SQRT_STEPS];
  assign axis_o = axis_q[SQRT_STEPS];

endmodule

### src/aar_div.sv
// ----------------------------------------------------------------------------
// aar_div
// Three restoring dividers in lockstep, one quotient bit per stage. Each
// gives round(|component| * 2^46 / length) with the component's sign, the
// unit axis in Q30.
// ----------------------------------------------------------------------------
module aar_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [aar_pkg::LEN_W-1:0] len_i,
  input  aar_pkg::axis_t            axis_i,
  output logic                      vld_o,
  output logic                      zero_o,
  output aar_pkg::q30_t             ux_o,
  output aar_pkg::q30_t             uy_o,
  output aar_pkg::q30_t             uz_o
);
  import aar_pkg::*;

  logic [31:0]   rem_q [DIV_STEPS+1][3];
  logic [31:0]   rem_d [DIV_STEPS+1][3];
  logic [30:0]   quo_q [DIV_STEPS+1][3];
  logic [30:0]   quo_d [DIV_STEPS+1][3];
  logic [30:0]   low_q [DIV_STEPS+1];
  logic [30:0]   low_d [DIV_STEPS+1];
  logic [31:0]   len_q [DIV_STEPS+1];
  logic [2:0]    neg_q [DIV_STEPS+1];
  logic          zero_q [DIV_STEPS+1];
  logic          vld_q [DIV_STEPS+1];
  q30_t          u_q [3];
  logic          zero_out_q;
  logic          vld_out_q;

  logic signed [AXIS_W-1:0] comp [3];

  assign comp[0] = axis_i.ax;
  assign comp[1] = axis_i.ay;
  assign comp[2] = axis_i.az;

  // Setup: the numerator splits into mag << 15 on top and length / 2 below.
  always_comb begin
    logic signed [16:0] c17;
    logic [15:0]        mag;
    logic [32:0]        r2;
    for (int l = 0; l < 3; l++) begin
      c17          = 17'(comp[l]);
      mag          = 16'((c17 < 0) ? -c17 : c17);
      rem_d[0][l]  = {1'b0, mag, 15'b0};
      quo_d[0][l]  = '0;
    end
    low_d[0] = len_i[31:1];
    for (int k = 1; k <= DIV_STEPS; k++) begin
      for (int l = 0; l < 3; l++) begin
        r2 = {rem_q[k-1][l], low_q[k-1][30]};
        if (r2 >= {1'b0, len_q[k-1]}) begin
          rem_d[k][l] = 32'(r2 - {1'b0, len_q[k-1]});
          quo_d[k][l] = {quo_q[k-1][l][29:0], 1'b1};
        end else begin
          rem_d[k][l] = r2[31:0];
          quo_d[k][l] = {quo_q[k-1][l][29:0], 1'b0};
        end
      end
      low_d[k] = {low_q[k-1][29:0], 1'b0};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld_q[k] <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= DIV_STEPS; k++) vld_q[k] <= vld_q[k-1];
      vld_out_q <= vld_q[DIV_STEPS];
    end
  end

  // Stage payload and the signed result.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0]  <= len_i;
      neg_q[0]  <= {comp[2] < 0, comp[1] < 0, comp[0] < 0};
      zero_q[0] <= axis_i.zero;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        low_q[k] <= low_d[k];
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
        len_q[k]  <= len_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        u_q[l] <= neg_q[DIV_STEPS][l] ? -$signed({1'b0, quo_q[DIV_STEPS][l]})
                                      : $signed({1'b0, quo_q[DIV_STEPS][l]});
      end
      zero_out_q <= zero_q[DIV_STEPS];
    end
  end

  assign vld_o  = vld_out_q;
  assign zero_o = zero_out_q;
  assign ux_o   = u_q[0];
  assign uy_o   = u_q[1];
  assign uz_o   = u_q[2];

endmodule

### src/aar_sincos.sv
// ----------------------------------------------------------------------------
// aar_sincos
// Angle reduction to one turn, scaling to a 32-bit binary angle, quadrant
// fold, and a pipelined CORDIC rotator with one iteration per stage.
// ----------------------------------------------------------------------------
module aar_sincos #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [aar_pkg::ANGLE_W-1:0] angle_i,
  output aar_pkg::q30_t                      cos_o,
  output aar_pkg::q30_t                      sin_o
);
  import aar_pkg::*;

  logic [14:0]        r_q;
  logic [14:0]        r_d;
  logic [19:0]        v_q;
  logic [19:0]        v_d;
  logic [32:0]        prod_q;
  logic [14:0]        q0_q;
  logic [14:0]        q0_d;
  logic [31:0]        theta_q;
  logic [31:0]        theta_d;

  logic signed [32:0] x_q [CORDIC_STEPS+1];
  logic signed [32:0] x_d [CORDIC_STEPS+1];
  logic signed [32:0] y_q [CORDIC_STEPS+1];
  logic signed [32:0] y_d [CORDIC_STEPS+1];
  logic signed [32:0] z_q [CORDIC_STEPS+1];
  logic signed [32:0] z_d [CORDIC_STEPS+1];
  logic               flip_q [CORDIC_STEPS+1];
  logic               flip_d;
  q30_t               cos_q;
  q30_t               sin_q;

  // Reduce the angle into one turn.
  always_comb begin
    logic signed [16:0] turn;
    logic signed [16:0] a0, a1, a2, a3;
    turn = 17'(FULL_TURN);
    a0   = 17'(angle_i);
    a1   = (a0 < 0) ? a0 + turn : a0;
    a2   = (a1 < 0) ? a1 + turn : a1;
    a3   = (a2 >= turn) ? a2 - turn : a2;
    r_d  = a3[14:0];
  end

  // Scale: theta = r * floor(2^23/45) + floor((23r + 22) / 45).
  always_comb begin
    logic [40:0] p;
    v_d  = 20'({5'b0, r_q} * THETA_RES + THETA_ADD);
    p    = 41'(v_d) * 41'(RECIP_K);
    q0_d = 15'(p >> RECIP_SH);
  end

  // Correct the reciprocal estimate by at most one.
  always_comb begin
    logic [19:0] rem;
    logic        corr;
    rem     = 20'(v_q - 20'(q0_q) * RECIP_DEN);
    corr    = rem >= RECIP_DEN;
    theta_d = 32'(prod_q + 33'(q0_q) + 33'(corr));
  end

  // Quadrant fold into [-90, 90] degrees, then the rotator iterations.
  always_comb begin
    logic signed [32:0] z;
    logic signed [32:0] atn;
    z      = 33'($signed(theta_q));
    flip_d = 1'b0;
    if (z > ONE_Q30) begin
      z      = z - HALF_TURN;
      flip_d = 1'b1;
    end else if (z < -ONE_Q30) begin
      z      = z + HALF_TURN;
      flip_d = 1'b1;
    end
    x_d[0] = CORDIC_GAIN;
    y_d[0] = '0;
    z_d[0] = z;
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      atn = $signed({1'b0, atan_lut(k - 1)});
      if (z_q[k-1] >= 0) begin
        x_d[k] = x_q[k-1] - (y_q[k-1] >>> (k - 1));
        y_d[k] = y_q[k-1] + (x_q[k-1] >>> (k - 1));
        z_d[k] = z_q[k-1] - atn;
      end else begin
        x_d[k] = x_q[k-1] + (y_q[k-1] >>> (k - 1));
        y_d[k] = y_q[k-1] - (x_q[k-1] >>> (k - 1));
        z_d[k] = z_q[k-1] + atn;
      end
    end
  end

  // Stage registers; the pipeline carries no control state of its own.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q     <= r_d;
      v_q     <= v_d;
      prod_q  <= 33'(r_q) * 33'(THETA_MUL);
      q0_q    <= q0_d;
      theta_q <= theta_d;
      flip_q[0] <= flip_d;
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
      end
      for (int k = 1; k <= CORDIC_STEPS; k++) flip_q[k] <= flip_q[k-1];
      cos_q <= 32'(flip_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS]);
      sin_q <= 32'(flip_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS]);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

### src/aar_mat.sv
// ----------------------------------------------------------------------------
// aar_mat
// Rodrigues products and sums, R = c*I + (1-c)*u*u^T + s*[u]x, then the
// rounded and saturated Q2.14 output register.
// ----------------------------------------------------------------------------
module aar_mat (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic            zero_i,
  input  aar_pkg::q30_t   ux_i,
  input  aar_pkg::q30_t   uy_i,
  input  aar_pkg::q30_t   uz_i,
  input  aar_pkg::q30_t   cos_i,
  input  aar_pkg::q30_t   sin_i,
  output logic            vld_o,
  output logic            zero_o,
  output aar_pkg::q14_t   m_o [9]
);
  import aar_pkg::*;

  // Q30 product rounded half up.
  function automatic logic signed [32:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + 66'sd536870912) >>> 30;
    return 33'(r);
  endfunction

  logic               vld_q [4];
  logic               zero_q [4];

  // First products.
  logic signed [32:0] uu_q [6];
  logic signed [32:0] us_q [3];
  logic signed [32:0] t_q;
  q30_t               c1_q;
  // Second products.
  logic signed [32:0] uut_q [6];
  logic signed [32:0] us2_q [3];
  q30_t               c2_q;
  // Sums and output.
  logic signed [33:0] m_q [9];
  q14_t               out_q [9];
  q14_t               out_d [9];

  // Saturated Q2.14 values, or the identity for a zero axis.
  always_comb begin
    logic signed [33:0] q;
    for (int j = 0; j < 9; j++) begin
      q = (m_q[j] + 34'sd32768) >>> 16;
      if (q > 34'(Q14_MAX)) q = 34'(Q14_MAX);
      if (q < -34'(Q14_MAX)) q = -34'(Q14_MAX);
      out_d[j] = 16'(q);
      if (zero_q[2]) out_d[j] = (j % 4 == 0) ? 16'(Q14_MAX) : '0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < 4; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= zero_i;
      for (int k = 1; k < 4; k++) zero_q[k] <= zero_q[k-1];

      uu_q[0] <= rnd30(66'(ux_i) * 66'(ux_i));
      uu_q[1] <= rnd30(66'(uy_i) * 66'(uy_i));
      uu_q[2] <= rnd30(66'(uz_i) * 66'(uz_i));
      uu_q[3] <= rnd30(66'(ux_i) * 66'(uy_i));
      uu_q[4] <= rnd30(66'(ux_i) * 66'(uz_i));
      uu_q[5] <= rnd30(66'(uy_i) * 66'(uz_i));
      us_q[0] <= rnd30(66'(ux_i) * 66'(sin_i));
      us_q[1] <= rnd30(66'(uy_i) * 66'(sin_i));
      us_q[2] <= rnd30(66'(uz_i) * 66'(sin_i));
      t_q     <= ONE_Q30 - 33'(cos_i);
      c1_q    <= cos_i;

      for (int j = 0; j < 6; j++) uut_q[j] <= rnd30(66'(uu_q[j]) * 66'(t_q));
      for (int j = 0; j < 3; j++) us2_q[j] <= us_q[j];
      c2_q <= c1_q;

      // Order of uut: xx, yy, zz, xy, xz, yz; of us2: xs, ys, zs.
      m_q[0] <= 34'(uut_q[0]) + 34'(c2_q);
      m_q[1] <= 34'(uut_q[3]) - 34'(us2_q[2]);
      m_q[2] <= 34'(uut_q[4]) + 34'(us2_q[1]);
      m_q[3] <= 34'(uut_q[3]) + 34'(us2_q[2]);
      m_q[4] <= 34'(uut_q[1]) + 34'(c2_q);
      m_q[5] <= 34'(uut_q[5]) - 34'(us2_q[0]);
      m_q[6] <= 34'(uut_q[4]) - 34'(us2_q[1]);
      m_q[7] <= 34'(uut_q[5]) + 34'(us2_q[0]);
      m_q[8] <= 34'(uut_q[2]) + 34'(c2_q);

      for (int j = 0; j < 9; j++) out_q[j] <= out_d[j];
    end
  end

  assign vld_o  = vld_q[3];
  assign zero_o = zero_q[3];
  assign m_o    = out_q;

endmodule
